>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHHI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CHHI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/chhi_pkg.sv
// ----------------------------------------------------------------------------
// Compass heading package
// Widths, reset values, register indexes, sequencer states and the
// arctangent table shared by the compass heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chhi_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int HEAD_W    = 15;
    localparam int VEC_W     = 18;
    localparam int PRE_SHIFT = 20;
    localparam int ANG_BITS  = 20;
    localparam int ACC_W     = VEC_W + PRE_SHIFT + 3;
    localparam int ANG_W     = 30;
    localparam int ATAN_W    = 26;
    localparam int TABLE_LEN = 24;
    localparam int STEP_W    = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int FRAC_BITS_DEF    = 6;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

    localparam logic REG_IDX_APPLY_CAL = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_WRAP,
        ST_ROUND
    } state_t;

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 26'd47185920;
                5'd1:    val = 26'd27855475;
                5'd2:    val = 26'd14718068;
                5'd3:    val = 26'd7471121;
                5'd4:    val = 26'd3750058;
                5'd5:    val = 26'd1876857;
                5'd6:    val = 26'd938658;
                5'd7:    val = 26'd469357;
                5'd8:    val = 26'd234682;
                5'd9:    val = 26'd117342;
                5'd10:   val = 26'd58671;
                5'd11:   val = 26'd29335;
                5'd12:   val = 26'd14668;
                5'd13:   val = 26'd7334;
                5'd14:   val = 26'd3667;
                5'd15:   val = 26'd1833;
                5'd16:   val = 26'd917;
                5'd17:   val = 26'd458;
                5'd18:   val = 26'd229;
                5'd19:   val = 26'd115;
                5'd20:   val = 26'd57;
                5'd21:   val = 26'd29;
                5'd22:   val = 26'd14;
                5'd23:   val = 26'd7;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

>>> rtl/chhi_if.sv
// ----------------------------------------------------------------------------
// Compass heading channel interfaces
// Valid/ready channels for magnetometer samples and heading results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chhi_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  raw_x;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  raw_y;
    logic                                  learn;

    modport source (output valid, raw_x, raw_y, learn, input ready);
    modport sink   (input valid, raw_x, raw_y, learn, output ready);
endinterface

interface chhi_out_if;
    logic                                  valid;
    logic                                  ready;
    logic        [chhi_pkg::HEAD_W-1:0]    heading;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  x_low;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  x_high;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  y_low;
    logic signed [chhi_pkg::SAMPLE_W-1:0]  y_high;

    modport source (output valid, heading, x_low, x_high, y_low, y_high, input ready);
    modport sink   (input valid, heading, x_low, x_high, y_low, y_high, output ready);
endinterface

>>> rtl/compass_heading_hard_iron.sv
// ----------------------------------------------------------------------------
// Compass heading with hard-iron learning
// Each sample transaction optionally widens the stored X/Y extremes, then a
// vectoring CORDIC turns the raw or hard-iron corrected vector into a heading
// in 1/2^FRAC_BITS degree steps, returned with the current extremes. The
// states run in order: IDLE accepts the sample, PREP forms the vector,
// ITER does the CORDIC rotations through the single shift-add datapath,
// WRAP wraps the angle and ROUND rounds it, waiting while an earlier
// result is still unread. The block takes one sample at a time; a finished
// result waits in the output register while the next sample is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compass_heading_hard_iron #(
    parameter int FRAC_BITS    = chhi_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = chhi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [chhi_pkg::PADDR_W-1:0]   paddr,
    input  logic [chhi_pkg::PDATA_W-1:0]   pwdata,
    output logic [chhi_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    chhi_in_if.sink                        sample,
    chhi_out_if.source                     result
);

    localparam int SW = chhi_pkg::SAMPLE_W;
    localparam int VW = chhi_pkg::VEC_W;
    localparam int AW = chhi_pkg::ACC_W;
    localparam int ZW = chhi_pkg::ANG_W;
    localparam int HW = chhi_pkg::HEAD_W;
    localparam int NW = chhi_pkg::STEP_W;

    localparam int LAST_STEP = ((CORDIC_STEPS < chhi_pkg::TABLE_LEN) ?
                                CORDIC_STEPS : chhi_pkg::TABLE_LEN) - 1;
    localparam int RND_SHIFT = chhi_pkg::ANG_BITS - FRAC_BITS;

    localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 << chhi_pkg::ANG_BITS);
    localparam logic signed [ZW-1:0] FULL_TURN_Z = ZW'(360 << chhi_pkg::ANG_BITS);
    localparam logic signed [ZW-1:0] RND_HALF    = ZW'(1 << (RND_SHIFT - 1));
    localparam logic        [ZW-1:0] FULL_TURN_H = ZW'(360 << FRAC_BITS);
    localparam logic        [NW-1:0] LAST_IDX    = NW'(LAST_STEP);

    chhi_pkg::state_t state_reg, state_next;

    logic                   apply_cal_reg;
    logic signed [SW-1:0]   min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [SW-1:0]   min_x_next, max_x_next, min_y_next, max_y_next;
    logic signed [SW-1:0]   sx_reg, sy_reg;
    logic signed [AW-1:0]   x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]   z_reg, z_next;
    logic                   zero_reg, zero_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HW-1:0]          heading_reg, heading_next;
    logic                   out_load;

    logic                   in_acc;
    logic                   cfg_wr;
    logic signed [VW-1:0]   vx_w, vy_w;
    logic signed [AW-1:0]   ax_w, ay_w, xsh_w, ysh_w;
    logic signed [ZW-1:0]   atan_w, zwrap_w;
    logic        [ZW-1:0]   hq_w, hfix_w;

    assign in_acc       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == chhi_pkg::ST_IDLE);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == chhi_pkg::REG_IDX_APPLY_CAL);
    assign prdata = (paddr[2] == chhi_pkg::REG_IDX_APPLY_CAL) ?
                    {{(chhi_pkg::PDATA_W-1){1'b0}}, apply_cal_reg} : '0;

    always_comb
    begin
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (in_acc && sample.learn)
        begin
            if (sample.raw_x < min_x_reg)
            begin
                min_x_next = sample.raw_x;
            end
            if (sample.raw_x > max_x_reg)
            begin
                max_x_next = sample.raw_x;
            end
            if (sample.raw_y < min_y_reg)
            begin
                min_y_next = sample.raw_y;
            end
            if (sample.raw_y > max_y_reg)
            begin
                max_y_next = sample.raw_y;
            end
        end
    end

    always_comb
    begin
        if (apply_cal_reg)
        begin
            vx_w = (VW'(sx_reg) <<< 1) - VW'(max_x_reg) - VW'(min_x_reg);
            vy_w = (VW'(sy_reg) <<< 1) - VW'(max_y_reg) - VW'(min_y_reg);
        end
        else
        begin
            vx_w = VW'(sx_reg);
            vy_w = VW'(sy_reg);
        end
        ax_w = AW'(vx_w) <<< chhi_pkg::PRE_SHIFT;
        ay_w = AW'(vy_w) <<< chhi_pkg::PRE_SHIFT;
    end

    assign xsh_w   = x_reg >>> cnt_reg;
    assign ysh_w   = y_reg >>> cnt_reg;
    assign atan_w  = signed'(ZW'(chhi_pkg::atan_lut(cnt_reg)));
    assign zwrap_w = z_reg[ZW-1] ? (z_reg + FULL_TURN_Z) : z_reg;
    assign hq_w    = unsigned'(z_reg) >> RND_SHIFT;
    assign hfix_w  = (hq_w >= FULL_TURN_H) ? (hq_w - FULL_TURN_H) : hq_w;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        cnt_next       = cnt_reg;
        heading_next   = heading_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            chhi_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = chhi_pkg::ST_PREP;
                end
            end
            chhi_pkg::ST_PREP:
            begin
                zero_next = (vx_w == '0) && (vy_w == '0);
                cnt_next  = '0;
                if (vx_w < 0)
                begin
                    x_next = -ax_w;
                    y_next = -ay_w;
                    z_next = HALF_TURN_Z;
                end
                else
                begin
                    x_next = ax_w;
                    y_next = ay_w;
                    z_next = '0;
                end
                state_next = chhi_pkg::ST_ITER;
            end
            chhi_pkg::ST_ITER:
            begin
                if (!y_reg[AW-1])
                begin
                    x_next = x_reg + ysh_w;
                    y_next = y_reg - xsh_w;
                    z_next = z_reg + atan_w;
                end
                else
                begin
                    x_next = x_reg - ysh_w;
                    y_next = y_reg + xsh_w;
                    z_next = z_reg - atan_w;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = chhi_pkg::ST_WRAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            chhi_pkg::ST_WRAP:
            begin
                z_next     = zwrap_w + RND_HALF;
                state_next = chhi_pkg::ST_ROUND;
            end
            chhi_pkg::ST_ROUND:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    heading_next   = zero_reg ? '0 : hfix_w[HW-1:0];
                    state_next     = chhi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chhi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chhi_pkg::ST_IDLE;
            apply_cal_reg <= 1'b0;
            min_x_reg     <= chhi_pkg::MIN_RESET;
            max_x_reg     <= chhi_pkg::MAX_RESET;
            min_y_reg     <= chhi_pkg::MIN_RESET;
            max_y_reg     <= chhi_pkg::MAX_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr)
            begin
                apply_cal_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sx_reg <= sample.raw_x;
            sy_reg <= sample.raw_y;
        end
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zero_reg    <= zero_next;
        heading_reg <= heading_next;
        if (out_load)
        begin
            result.x_low  <= min_x_reg;
            result.x_high <= max_x_reg;
            result.y_low  <= min_y_reg;
            result.y_high <= max_y_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.heading = heading_reg;

endmodule

>>> rtl/chhi_checker.sv
// ----------------------------------------------------------------------------
// Compass heading port checker
// Watches the sample and result channels of the compass heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chhi_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic        [chhi_pkg::HEAD_W-1:0]   heading,
    input logic signed [chhi_pkg::SAMPLE_W-1:0] x_low,
    input logic signed [chhi_pkg::SAMPLE_W-1:0] x_high,
    input logic signed [chhi_pkg::SAMPLE_W-1:0] y_low,
    input logic signed [chhi_pkg::SAMPLE_W-1:0] y_high
);

    // The block works on one sample transaction at a time.
    `CHHI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

    `CHHI_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(heading) && $stable(x_low) && $stable(y_high), "stalled result changed")

    // Once anything has been learned, the stored minimum cannot exceed the maximum.
    `CHHI_ASSERT_IMPLY(a_x_order, out_valid && (x_high != chhi_pkg::MAX_RESET), x_low <= x_high, "x extremes out of order")

    `CHHI_ASSERT_IMPLY(a_y_order, out_valid && (y_high != chhi_pkg::MAX_RESET), y_low <= y_high, "y extremes out of order")

endmodule

bind compass_heading_hard_iron chhi_checker u_chhi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .heading   (result.heading),
    .x_low     (result.x_low),
    .x_high    (result.x_high),
    .y_low     (result.y_low),
    .y_high    (result.y_high)
);
